// ----- design/hfmp_pkg.sv -----
`default_nettype none

package hfmp_pkg;

    // Configuration register map
    localparam int CFG_IW = 8;
    localparam logic [CFG_IW-1:0] REG_YAW_STEP  = 8'd0;
    localparam logic [CFG_IW-1:0] REG_TIME_STEP = 8'd1;

    localparam logic [10:0] YAW_STEP_RST  = 11'd410;
    localparam logic [15:0] TIME_STEP_RST = 16'd6554;

    // Angle constants, radians Q28
    localparam longint PI_Q28      = 843314857;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint TWO_PI_Q28  = 1686629714;

    // CORDIC start value (gain compensated), Q30
    localparam longint CORDIC_K_Q30 = 652032874;
    localparam int CORDIC_ITERS = 24;

    // Range reduction steps by 2*pi, enough for the widest heading sum
    localparam int RED_STEPS = 4;

    // Widths of the CORDIC datapath
    localparam int ZW = 32;
    localparam int XW = 34;

    typedef logic signed [ZW-1:0] ang_t;
    typedef logic signed [XW-1:0] vec_t;

    // Arctangent table, Q28
    function automatic ang_t atan_q28(input int i);
        ang_t r;
        case (i)
            0:  r = 32'sd210828714;
            1:  r = 32'sd124459457;
            2:  r = 32'sd65760959;
            3:  r = 32'sd33381290;
            4:  r = 32'sd16755422;
            5:  r = 32'sd8385879;
            6:  r = 32'sd4193963;
            7:  r = 32'sd2097109;
            8:  r = 32'sd1048571;
            9:  r = 32'sd524287;
            10: r = 32'sd262144;
            11: r = 32'sd131072;
            12: r = 32'sd65536;
            13: r = 32'sd32768;
            14: r = 32'sd16384;
            15: r = 32'sd8192;
            16: r = 32'sd4096;
            17: r = 32'sd2048;
            18: r = 32'sd1024;
            19: r = 32'sd512;
            20: r = 32'sd256;
            21: r = 32'sd128;
            22: r = 32'sd64;
            23: r = 32'sd32;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/hfmp_in_if.sv -----
`default_nettype none

interface hfmp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [14:0] heading;
    logic        [15:0] speed;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output speed, input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading,
                  input speed, output ready);
endinterface

`default_nettype wire

// ----- design/hfmp_out_if.sv -----
`default_nettype none

interface hfmp_out_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  branch_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [15:0] out_heading;
    logic        [15:0] out_speed;
    logic               last_branch;

    modport source (output valid, output branch_index, output out_x, output out_y,
                    output out_heading, output out_speed, output last_branch,
                    input ready);
    modport sink (input valid, input branch_index, input out_x, input out_y,
                  input out_heading, input out_speed, input last_branch,
                  output ready);
endinterface

`default_nettype wire

// ----- design/hfmp_cfg_if.sv -----
`default_nettype none

interface hfmp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [hfmp_pkg::CFG_IW-1:0]  index;
    logic [31:0]                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/heading_fan_motion_predictor_core.sv -----
`default_nettype none

// Motion fan predictor: each input word (x, y, heading, speed) yields BRANCHES
// result words, branch k at heading + (k - BRANCHES/2) * yaw_step, with the
// position advanced by speed * time_step along that heading. A branch
// sequencer issues one branch per cycle, unless stalled, into a 33-stage
// pipeline (heading sum, 2*pi reduction, quadrant fold, one CORDIC iteration
// per stage, trig sign/magnitude, multiply, round and saturate), so results
// stream out one per cycle while the output is not stalled, and the next input
// word is taken in the cycle the last branch of the current one issues.
// Output backpressure stalls the whole pipeline.
// Registers: index 0 yaw_step (11 bits), index 1 time_step (16 bits); writes
// to other indexes are dropped. Write them only while the block is idle.
module heading_fan_motion_predictor_core #(
    parameter int BRANCHES = 10
) (
    input  wire          clk,
    input  wire          rst_n,
    hfmp_in_if.sink      in_ch,
    hfmp_out_if.source   out_ch,
    hfmp_cfg_if.sink     cfg
);
    import hfmp_pkg::*;

    localparam int KW    = $clog2(BRANCHES);
    localparam int OW    = KW + 1;
    localparam int PW    = OW + 12;
    localparam int HW    = ((PW > 15) ? PW : 15) + 1;
    localparam int AW    = HW + 17;
    localparam int ST_F  = RED_STEPS + 1;
    localparam int ST_T  = ST_F + CORDIC_ITERS + 1;
    localparam int ST_M  = ST_T + 1;
    localparam int ST_O  = ST_M + 1;
    localparam int NST   = ST_O + 1;

    typedef struct packed {
        logic [KW-1:0]      k;
        logic               last;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        hd16;
        logic [15:0]        sp;
        logic [31:0]        st;
    } pass_t;

    // Configuration registers
    logic [10:0] yaw_step_reg;
    logic [15:0] time_step_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_step_reg  <= YAW_STEP_RST;
            time_step_reg <= TIME_STEP_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_YAW_STEP:  yaw_step_reg  <= cfg.data[10:0];
                REG_TIME_STEP: time_step_reg <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: the last stage is the output register
    logic [NST-1:0] v_reg;
    logic adv;
    assign adv = !v_reg[ST_O] || out_ch.ready;

    // Branch sequencer
    logic               busy_reg;
    logic [KW-1:0]      cnt_reg;
    logic signed [31:0] cur_px_reg;
    logic signed [31:0] cur_py_reg;
    logic signed [14:0] cur_hd_reg;
    logic [15:0]        cur_sp_reg;
    logic               last_issue;
    logic               take;

    assign last_issue  = (cnt_reg == KW'(BRANCHES - 1));
    assign in_ch.ready = !busy_reg || (adv && last_issue);
    assign take        = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (adv && busy_reg)
        begin
            if (last_issue)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + KW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_px_reg <= in_ch.pos_x;
            cur_py_reg <= in_ch.pos_y;
            cur_hd_reg <= in_ch.heading;
            cur_sp_reg <= in_ch.speed;
        end
    end

    // Branch heading: heading + (k - BRANCHES/2) * yaw_step
    logic signed [OW-1:0] off;
    logic signed [PW-1:0] off_prod;
    logic signed [HW-1:0] h_sum;

    assign off      = $signed({1'b0, cnt_reg}) - OW'(BRANCHES / 2);
    assign off_prod = PW'(off) * $signed({1'b0, yaw_step_reg});
    assign h_sum    = HW'(cur_hd_reg) + HW'(off_prod);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NST-2:0], busy_reg};
    end

    // Pass-through payload, one copy per stage
    pass_t                p_reg [0:NST-1];
    logic signed [HW-1:0] h_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= '{k: cnt_reg, last: last_issue, px: cur_px_reg,
                          py: cur_py_reg, hd16: h_sum[15:0], sp: cur_sp_reg,
                          st: 32'(cur_sp_reg) * 32'(time_step_reg)};
            h_reg <= h_sum;
            for (int i = 1; i < NST; i++)
                p_reg[i] <= p_reg[i-1];
        end
    end

    // Reduction into minus pi to pi, one 2*pi step per stage
    logic signed [AW-1:0] rz_reg [1:RED_STEPS];

    for (genvar g = 1; g <= RED_STEPS; g++)
    begin : g_red
        logic signed [AW-1:0] src;
        if (g == 1)
        begin : g_first
            assign src = AW'(h_reg) <<< 16;
        end
        else
        begin : g_next
            assign src = rz_reg[g-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (src > AW'(PI_Q28))
                    rz_reg[g] <= src - AW'(TWO_PI_Q28);
                else if (src < -AW'(PI_Q28))
                    rz_reg[g] <= src + AW'(TWO_PI_Q28);
                else
                    rz_reg[g] <= src;
            end
        end
    end

    // Quadrant fold and CORDIC stages
    ang_t cz_reg  [0:CORDIC_ITERS];
    vec_t cx_reg  [0:CORDIC_ITERS];
    vec_t cy_reg  [0:CORDIC_ITERS];
    logic neg_reg [0:CORDIC_ITERS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0] <= XW'(CORDIC_K_Q30);
            cy_reg[0] <= '0;
            if (rz_reg[RED_STEPS] > AW'(HALF_PI_Q28))
            begin
                cz_reg[0]  <= ZW'(rz_reg[RED_STEPS] - AW'(PI_Q28));
                neg_reg[0] <= 1'b1;
            end
            else if (rz_reg[RED_STEPS] < -AW'(HALF_PI_Q28))
            begin
                cz_reg[0]  <= ZW'(rz_reg[RED_STEPS] + AW'(PI_Q28));
                neg_reg[0] <= 1'b1;
            end
            else
            begin
                cz_reg[0]  <= ZW'(rz_reg[RED_STEPS]);
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < CORDIC_ITERS; g++)
    begin : g_cordic
        vec_t dx;
        vec_t dy;
        assign dx = cy_reg[g] >>> g;
        assign dy = cx_reg[g] >>> g;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                neg_reg[g+1] <= neg_reg[g];
                if (!cz_reg[g][ZW-1])
                begin
                    cx_reg[g+1] <= cx_reg[g] - dx;
                    cy_reg[g+1] <= cy_reg[g] + dy;
                    cz_reg[g+1] <= cz_reg[g] - atan_q28(g);
                end
                else
                begin
                    cx_reg[g+1] <= cx_reg[g] + dx;
                    cy_reg[g+1] <= cy_reg[g] - dy;
                    cz_reg[g+1] <= cz_reg[g] + atan_q28(g);
                end
            end
        end
    end

    function automatic logic [31:0] mag32(input vec_t v);
        vec_t a;
        a = v[XW-1] ? -v : v;
        return a[31:0];
    endfunction

    // Trig sign and magnitude, then displacement products
    logic        sx_reg;
    logic        sy_reg;
    logic [31:0] mx_reg;
    logic [31:0] my_reg;
    logic        msx_reg;
    logic        msy_reg;
    logic [63:0] prx_reg;
    logic [63:0] pry_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg  <= cx_reg[CORDIC_ITERS][XW-1] ^ neg_reg[CORDIC_ITERS];
            sy_reg  <= cy_reg[CORDIC_ITERS][XW-1] ^ neg_reg[CORDIC_ITERS];
            mx_reg  <= mag32(cx_reg[CORDIC_ITERS]);
            my_reg  <= mag32(cy_reg[CORDIC_ITERS]);
            msx_reg <= sx_reg;
            msy_reg <= sy_reg;
            prx_reg <= 64'(p_reg[ST_T].st) * 64'(mx_reg);
            pry_reg <= 64'(p_reg[ST_T].st) * 64'(my_reg);
        end
    end

    // Round magnitude half away from zero to Q16, reapply sign, add, saturate
    function automatic logic signed [31:0] apply_disp(input logic signed [31:0] pos,
                                                      input logic [63:0] prod,
                                                      input logic neg);
        logic [63:0]        rnd;
        logic signed [26:0] d;
        logic signed [32:0] s;
        rnd = prod + (64'd1 << 37);
        d   = neg ? -$signed({1'b0, rnd[63:38]}) : $signed({1'b0, rnd[63:38]});
        s   = 33'(pos) + 33'(d);
        if (s > 33'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (s < -33'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

    logic signed [31:0] ox_reg;
    logic signed [31:0] oy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg <= apply_disp(p_reg[ST_M].px, prx_reg, msx_reg);
            oy_reg <= apply_disp(p_reg[ST_M].py, pry_reg, msy_reg);
        end
    end

    // Output word
    assign out_ch.valid        = v_reg[ST_O];
    assign out_ch.branch_index = 4'(p_reg[ST_O].k);
    assign out_ch.out_x        = ox_reg;
    assign out_ch.out_y        = oy_reg;
    assign out_ch.out_heading  = p_reg[ST_O].hd16;
    assign out_ch.out_speed    = p_reg[ST_O].sp;
    assign out_ch.last_branch  = p_reg[ST_O].last;

`ifndef SYNTHESIS
    // A new word is taken only when idle or while the last branch issues
    a_take_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (take && busy_reg) |-> (last_issue && adv))
        else $error("input word taken mid fan");

    // Branch counter holds while the pipeline is stalled
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !adv) |=> $stable(cnt_reg))
        else $error("branch counter moved during stall");

    // Last flag marks exactly the final branch
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.last_branch == (p_reg[ST_O].k == KW'(BRANCHES - 1))))
        else $error("last_branch does not match branch index");

    // Branches issue in order: after a non-final issue the next index follows
    a_issue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && adv && !last_issue && !take) |=> (cnt_reg == $past(cnt_reg) + KW'(1)))
        else $error("branch index skipped");
`endif

endmodule

`default_nettype wire
